### src/rtas_pkg.sv
`default_nettype none
package rtas_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int MAX_CHANNELS = 8;
  localparam int POS_W = 15;
  localparam int CNT_W = 12;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [POS_W-1:0] POS_MAX = 15'h7fff;
  localparam logic [27:0] ROUND_BIAS = 28'd16383;
  localparam logic [CNT_W-1:0] CNT_MAX = 12'd4095;
  localparam logic [CNT_W-1:0] HALF_LEVEL = 12'h200;
  localparam logic [CNT_W-1:0] FULL_LEVEL = 12'h400;

  localparam logic [31:0] MAP_RESET = 32'h76543210;
  localparam logic [CNT_W-1:0] X_FIRST_RESET = 12'd160;
  localparam logic [CNT_W-1:0] X_LAST_RESET = 12'd3712;
  localparam logic [CNT_W-1:0] Y_FIRST_RESET = 12'd3964;
  localparam logic [CNT_W-1:0] Y_LAST_RESET = 12'd211;
  localparam logic [CNT_W-1:0] VDDIO_RESET = 12'd2304;
  localparam logic [CNT_W-1:0] BATTERY_RESET = 12'd2816;

  localparam logic [3:0] PHYS_XY = 4'd2;
  localparam logic [3:0] PHYS_X_TRIG = 4'd3;
  localparam logic [3:0] PHYS_PEN = 4'd4;
  localparam logic [3:0] PHYS_Y = 4'd5;
  localparam logic [3:0] PHYS_VDDIO = 4'd6;
  localparam logic [3:0] PHYS_BATTERY = 4'd7;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_BURST  = 2'd1,
    OP_ACK    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_UP      = 2'd0,
    PH_DOWN    = 2'd1,
    PH_LIFTING = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP     = 4'd0,
    CFG_X_FIRST = 4'd1,
    CFG_X_LAST  = 4'd2,
    CFG_Y_FIRST = 4'd3,
    CFG_Y_LAST  = 4'd4,
    CFG_VDDIO   = 4'd5,
    CFG_BATTERY = 4'd6,
    CFG_IRQ_EN  = 4'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STATUS,
    ST_LATCH,
    ST_SCAN,
    ST_ISSUE_X,
    ST_ISSUE_Y,
    ST_TAKE_X,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0]      channel_map;
    logic [CNT_W-1:0] plate_x_first;
    logic [CNT_W-1:0] plate_x_last;
    logic [CNT_W-1:0] plate_y_first;
    logic [CNT_W-1:0] plate_y_last;
    logic [CNT_W-1:0] vddio_level;
    logic [CNT_W-1:0] battery_level;
    logic             touch_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic             issue;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] first;
    logic [CNT_W-1:0] last;
  } plate_req_t;

  function automatic logic [CNT_W-1:0] phys_sample(
    input logic [3:0]       phys,
    input logic [7:0]       trigger,
    input logic             down,
    input logic [CNT_W-1:0] x,
    input logic [CNT_W-1:0] y,
    input logic [CNT_W-1:0] vddio,
    input logic [CNT_W-1:0] battery
  );
    logic [CNT_W-1:0] s;
    unique case (phys)
      PHYS_XY:      s = ((trigger & 8'hfb) == 8'h00) ? y : x;
      PHYS_X_TRIG:  s = trigger[3] ? x : (down ? HALF_LEVEL : '0);
      PHYS_PEN:     s = down ? FULL_LEVEL : '0;
      PHYS_Y:       s = y;
      PHYS_VDDIO:   s = vddio;
      PHYS_BATTERY: s = battery;
      default:      s = FULL_LEVEL;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

### src/rtas_if.sv
`default_nettype none
interface rtas_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] pointer_x;
  logic [15:0] pointer_y;
  logic        pen_pressed;
  logic [7:0]  channel_mask;
  logic        fresh_kick;

  modport source (output valid, op, pointer_x, pointer_y, pen_pressed, channel_mask,
                  fresh_kick, input ready);
  modport sink (input valid, op, pointer_x, pointer_y, pen_pressed, channel_mask,
                fresh_kick, output ready);
endinterface

interface rtas_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  virtual_channel;
  logic [11:0] sample;
  logic        touch_irq;
  logic        wake_pulse;
  logic        last;

  modport source (output valid, kind, virtual_channel, sample, touch_irq, wake_pulse, last,
                  input ready);
  modport sink (input valid, kind, virtual_channel, sample, touch_irq, wake_pulse, last,
                output ready);
endinterface
`default_nettype wire

### src/rtas_plate_unit.sv
`default_nettype none
module rtas_plate_unit
  import rtas_pkg::*;
(
  input  wire logic             clk,
  input  plate_req_t            req,
  output logic      [CNT_W-1:0] count
);

  logic signed [12:0] span;
  logic signed [15:0] pos_s;
  logic signed [28:0] prod_d;
  logic signed [28:0] prod;
  logic [CNT_W-1:0]   first;
  logic               neg;
  logic [27:0]        mag;
  logic [27:0]        u;
  logic [12:0]        q1;
  logic [16:0]        r;
  logic [12:0]        q;
  logic signed [14:0] v;
  logic [CNT_W-1:0]   count_next;

  assign span = $signed({1'b0, req.last}) - $signed({1'b0, req.first});
  assign pos_s = $signed({1'b0, req.pos});
  assign prod_d = span * pos_s;

  always_ff @(posedge clk) begin
    if (req.issue) begin
      prod <= prod_d;
      first <= req.first;
    end
  end

  // Rounding division by 32767 through the shift-and-fold identity.
  always_comb begin
    neg = prod[28];
    mag = neg ? 28'(-prod) : 28'(prod);
    if (!neg) begin
      u = mag + ROUND_BIAS;
    end else if (mag > ROUND_BIAS) begin
      u = mag - ROUND_BIAS;
    end else begin
      u = '0;
    end
    q1 = u[27:15];
    r = {2'b00, u[14:0]} + {4'b0000, q1};
    q = q1 + 13'(r >= {2'b00, POS_MAX});
    v = neg ? $signed({3'b000, first}) - $signed({2'b00, q})
            : $signed({3'b000, first}) + $signed({2'b00, q});
    if (v < 0) begin
      count_next = '0;
    end else if (v > $signed({3'b000, CNT_MAX})) begin
      count_next = CNT_MAX;
    end else begin
      count_next = v[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    count <= count_next;
  end

endmodule
`default_nettype wire

### src/rtas_ctrl.sv
`default_nettype none
module rtas_ctrl
  import rtas_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  cfg_t                  cfg,
  rtas_in_if.sink               in_ch,
  rtas_out_if.source            out_ch,
  output plate_req_t            req,
  input  wire logic [CNT_W-1:0] count
);

  localparam logic [2:0] LAST_CH = 3'(NUM_CHANNELS - 1);

  state_t state, state_next;

  logic [7:0]       mask;
  logic             fresh;
  logic             wake;
  logic [2:0]       idx;
  logic [POS_W-1:0] cur_x, cur_y, release_x, release_y, latched_x, latched_y;
  logic             cur_down, latched_down, latch_valid, detect_flag;
  phase_t           pen_phase;
  logic [CNT_W-1:0] x_cnt;

  logic             out_valid;
  logic             out_kind;
  logic [2:0]       out_vch;
  logic [CNT_W-1:0] out_sample;
  logic             out_irq;
  logic             out_wake;
  logic             out_last;

  logic             slot_free;
  logic             accept;
  logic             load_status;
  logic             load_sample;
  logic             issue;
  logic             sel_y;
  logic [POS_W-1:0] src_x, src_y;
  logic             src_down;
  logic [7:0]       above;
  logic             more;
  logic [3:0]       phys;
  logic [CNT_W-1:0] x_val, y_val, sample_val;
  logic             irq;
  logic             down_in;
  logic [POS_W-1:0] clamp_x, clamp_y;

  assign slot_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign accept = in_ch.valid && (state == ST_IDLE);

  assign src_x = latch_valid ? latched_x : cur_x;
  assign src_y = latch_valid ? latched_y : cur_y;
  assign src_down = latch_valid ? latched_down : cur_down;

  always_comb begin
    for (int j = 0; j < MAX_CHANNELS; j++) begin
      above[j] = mask[j] && (3'(j) > idx) && (j < NUM_CHANNELS);
    end
  end
  assign more = |above;

  assign phys = cfg.channel_map[{idx, 2'b00} +: 4];
  assign x_val = src_down ? x_cnt : '0;
  assign y_val = src_down ? count : '0;
  assign sample_val = phys_sample(phys, mask, src_down, x_val, y_val,
                                  cfg.vddio_level, cfg.battery_level);
  assign irq = (detect_flag || pen_phase != PH_UP) && cfg.touch_irq_enable;

  assign down_in = in_ch.pen_pressed;
  assign clamp_x = (in_ch.pointer_x > {1'b0, POS_MAX}) ? POS_MAX : in_ch.pointer_x[POS_W-1:0];
  assign clamp_y = (in_ch.pointer_y > {1'b0, POS_MAX}) ? POS_MAX : in_ch.pointer_y[POS_W-1:0];

  assign req = {issue,
                (sel_y ? src_y : src_x),
                (sel_y ? cfg.plate_y_first : cfg.plate_x_first),
                (sel_y ? cfg.plate_y_last : cfg.plate_x_last)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue = 1'b0;
    sel_y = 1'b0;
    load_status = 1'b0;
    load_sample = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_next = (op_t'(in_ch.op) == OP_BURST) ? ST_LATCH : ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          load_status = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_LATCH: state_next = ST_SCAN;
      ST_SCAN: begin
        if (mask[idx]) begin
          state_next = ST_ISSUE_X;
        end else if (idx == LAST_CH) begin
          state_next = ST_STATUS;
        end
      end
      ST_ISSUE_X: begin
        issue = 1'b1;
        state_next = ST_ISSUE_Y;
      end
      ST_ISSUE_Y: begin
        issue = 1'b1;
        sel_y = 1'b1;
        state_next = ST_TAKE_X;
      end
      ST_TAKE_X: state_next = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          load_sample = 1'b1;
          state_next = more ? ST_SCAN : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
      cur_down <= 1'b0;
      release_x <= '0;
      release_y <= '0;
      pen_phase <= PH_UP;
      latched_x <= '0;
      latched_y <= '0;
      latched_down <= 1'b0;
      latch_valid <= 1'b0;
      detect_flag <= 1'b0;
      wake <= 1'b0;
      idx <= '0;
    end else begin
      if (accept) begin
        mask <= in_ch.channel_mask;
        fresh <= in_ch.fresh_kick;
        wake <= 1'b0;
        unique case (op_t'(in_ch.op))
          OP_UPDATE: begin
            if (cur_down && !down_in) begin
              release_x <= cur_x;
              release_y <= cur_y;
              pen_phase <= PH_LIFTING;
            end else if (down_in) begin
              pen_phase <= PH_DOWN;
            end
            cur_x <= clamp_x;
            cur_y <= clamp_y;
            cur_down <= down_in;
            if (!down_in) begin
              detect_flag <= 1'b0;
            end else if (!cur_down) begin
              detect_flag <= 1'b1;
              wake <= 1'b1;
            end
          end
          OP_ACK: detect_flag <= 1'b0;
          OP_BURST, OP_NONE: begin
          end
          default: begin
          end
        endcase
      end
      if (state == ST_LATCH) begin
        idx <= '0;
        if (!latch_valid || fresh) begin
          latch_valid <= 1'b1;
          unique case (pen_phase)
            PH_DOWN: begin
              latched_x <= cur_x;
              latched_y <= cur_y;
              latched_down <= 1'b1;
            end
            PH_LIFTING: begin
              latched_x <= release_x;
              latched_y <= release_y;
              latched_down <= 1'b1;
              pen_phase <= PH_UP;
            end
            default: begin
              latched_x <= cur_x;
              latched_y <= cur_y;
              latched_down <= 1'b0;
            end
          endcase
        end
      end
      if (state == ST_SCAN && !mask[idx] && idx != LAST_CH) begin
        idx <= idx + 3'd1;
      end
      if (load_sample) begin
        latch_valid <= 1'b0;
        if (more) begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_TAKE_X) begin
      x_cnt <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_status || load_sample) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      out_kind <= 1'b0;
      out_vch <= '0;
      out_sample <= '0;
      out_irq <= irq;
      out_wake <= wake;
      out_last <= 1'b1;
    end else if (load_sample) begin
      out_kind <= 1'b1;
      out_vch <= idx;
      out_sample <= sample_val;
      out_irq <= irq;
      out_wake <= 1'b0;
      out_last <= !more;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.kind = out_kind;
  assign out_ch.virtual_channel = out_vch;
  assign out_ch.sample = out_sample;
  assign out_ch.touch_irq = out_irq;
  assign out_ch.wake_pulse = out_wake;
  assign out_ch.last = out_last;

endmodule
`default_nettype wire

### src/resistive_touch_adc_sampler.sv
// Touch panel ADC front end with a valid/ready input channel and a valid/ready result channel.
// Each input transaction is a pointer update, a conversion burst or a detect acknowledge.
// A pointer update, an acknowledge or an undefined op returns one status transaction
// once the output register is free. A burst latches the pen sample and then scans the virtual
// channels one per cycle while none is selected; each selected channel runs the shared
// plate unit (one multiplier followed by a fold-and-correct divide by 32767) for X and
// then Y, and the scan waits until its result is loaded. A burst with no selected
// channel scans all NUM_CHANNELS and then returns a single status transaction.
// The input is ready only while the sequencer is idle; one item is in work at a time.
// Results leave through an output register, so an item can be accepted while the previous
// result still waits. When the receiver stalls, the sequencer holds before loading its next
// result and the input stays blocked until the item has loaded its last result.
// Configuration writes are registered; the user must write only while the block is idle,
// which the block does not enforce. A synchronous reset restores the register defaults,
// puts the pen in the up state, clears the latch and detect flag, and drops the output valid.
`default_nettype none
module resistive_touch_adc_sampler
  import rtas_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  rtas_in_if.sink                    in_ch,
  rtas_out_if.source                 out_ch
);

  cfg_t             cfg;
  plate_req_t       req;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_map <= MAP_RESET;
      cfg.plate_x_first <= X_FIRST_RESET;
      cfg.plate_x_last <= X_LAST_RESET;
      cfg.plate_y_first <= Y_FIRST_RESET;
      cfg.plate_y_last <= Y_LAST_RESET;
      cfg.vddio_level <= VDDIO_RESET;
      cfg.battery_level <= BATTERY_RESET;
      cfg.touch_irq_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAP:     cfg.channel_map <= cfg_data;
        CFG_X_FIRST: cfg.plate_x_first <= cfg_data[CNT_W-1:0];
        CFG_X_LAST:  cfg.plate_x_last <= cfg_data[CNT_W-1:0];
        CFG_Y_FIRST: cfg.plate_y_first <= cfg_data[CNT_W-1:0];
        CFG_Y_LAST:  cfg.plate_y_last <= cfg_data[CNT_W-1:0];
        CFG_VDDIO:   cfg.vddio_level <= cfg_data[CNT_W-1:0];
        CFG_BATTERY: cfg.battery_level <= cfg_data[CNT_W-1:0];
        CFG_IRQ_EN:  cfg.touch_irq_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  rtas_plate_unit u_plate (
    .clk   (clk),
    .req   (req),
    .count (count)
  );

  rtas_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .req    (req),
    .count  (count)
  );

endmodule
`default_nettype wire

### verif/rtas_checker.sv
module rtas_checker
  import rtas_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  rtas_in_if                         in_mon,
  rtas_out_if                        out_mon,
  output int                         fail_count,
  output int                         pending,
  output int                         checked
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic             kind;
    logic [2:0]       vch;
    logic [CNT_W-1:0] sample;
    logic             irq;
    logic             wake;
    logic             last;
  } touch_result_t;

  touch_result_t    expected_q[$];
  cfg_t             regs;
  logic [POS_W-1:0] pos_x, pos_y, lift_x, lift_y, hold_x, hold_y;
  logic             pen_on, hold_on, hold_live, touch_seen;
  phase_t           pen_mode;

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
  end

  function automatic logic [POS_W-1:0] clamp_pos(logic [15:0] v);
    return (v > {1'b0, POS_MAX}) ? POS_MAX : v[POS_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] plate_law(logic [POS_W-1:0] pos,
                                                 logic [CNT_W-1:0] first,
                                                 logic [CNT_W-1:0] last);
    longint full, lo, hi, p, v;
    full = POS_MAX;
    lo = first;
    hi = last;
    p = pos;
    v = lo + ((hi - lo) * p + full / 2) / full;
    if (v < 0) return '0;
    if (v > CNT_MAX) return CNT_MAX;
    return v[CNT_W-1:0];
  endfunction

  function automatic logic irq_now();
    return (touch_seen || pen_mode != PH_UP) && regs.touch_irq_enable;
  endfunction

  // The held pen sample serves one channel only; later channels see the live pen.
  function automatic logic [CNT_W-1:0] convert_channel(logic [3:0] phys, logic [7:0] trig);
    logic [POS_W-1:0] px, py;
    logic             on;
    logic [CNT_W-1:0] xc, yc, s;
    px = hold_live ? hold_x : pos_x;
    py = hold_live ? hold_y : pos_y;
    on = hold_live ? hold_on : pen_on;
    hold_live = 1'b0;
    xc = on ? plate_law(px, regs.plate_x_first, regs.plate_x_last) : '0;
    yc = on ? plate_law(py, regs.plate_y_first, regs.plate_y_last) : '0;
    case (phys)
      PHYS_XY:      s = ((trig & ~8'h04) == 8'h00) ? yc : xc;
      PHYS_X_TRIG:  s = trig[3] ? xc : (on ? HALF_LEVEL : '0);
      PHYS_PEN:     s = on ? FULL_LEVEL : '0;
      PHYS_Y:       s = yc;
      PHYS_VDDIO:   s = regs.vddio_level;
      PHYS_BATTERY: s = regs.battery_level;
      default:      s = FULL_LEVEL;
    endcase
    return s;
  endfunction

  function automatic void predict_item(op_t op, logic [15:0] x, logic [15:0] y, logic pen,
                                       logic [7:0] mask, logic kick);
    touch_result_t    r;
    logic [CNT_W-1:0] vals [MAX_CHANNELS];
    logic [2:0]       chans [MAX_CHANNELS];
    logic             press;
    int               n, i, k;
    r = '0;
    r.last = 1'b1;
    n = 0;
    case (op)
      OP_UPDATE: begin
        press = !pen_on && pen;
        if (pen_on && !pen) begin
          lift_x = pos_x;
          lift_y = pos_y;
          pen_mode = PH_LIFTING;
        end else if (pen) begin
          pen_mode = PH_DOWN;
        end
        pos_x = clamp_pos(x);
        pos_y = clamp_pos(y);
        pen_on = pen;
        if (!pen) begin
          touch_seen = 1'b0;
        end else if (press) begin
          touch_seen = 1'b1;
          r.wake = 1'b1;
        end
      end
      OP_BURST: begin
        if (!hold_live || kick) begin
          case (pen_mode)
            PH_DOWN: begin
              hold_x = pos_x;
              hold_y = pos_y;
              hold_on = 1'b1;
            end
            PH_LIFTING: begin
              hold_x = lift_x;
              hold_y = lift_y;
              hold_on = 1'b1;
              pen_mode = PH_UP;
            end
            default: begin
              hold_x = pos_x;
              hold_y = pos_y;
              hold_on = 1'b0;
            end
          endcase
          hold_live = 1'b1;
        end
        for (i = 0; i < NUM_CHANNELS_DEF; i++) begin
          if (mask[i]) begin
            chans[n] = 3'(i);
            vals[n] = convert_channel(regs.channel_map[4*i +: 4], mask);
            n++;
          end
        end
      end
      OP_ACK: touch_seen = 1'b0;
      default: ;
    endcase
    r.irq = irq_now();
    if (n == 0) expected_q.push_back(r);
    for (k = 0; k < n; k++) begin
      r.kind = 1'b1;
      r.vch = chans[k];
      r.sample = vals[k];
      r.last = (k == n - 1);
      expected_q.push_back(r);
    end
  endfunction

  function automatic string show(touch_result_t r);
    return $sformatf("kind=%0d ch=%0d sample=%0d irq=%0d wake=%0d last=%0d",
                     r.kind, r.vch, r.sample, r.irq, r.wake, r.last);
  endfunction

  function automatic void check_result();
    touch_result_t got, want;
    got = '{kind: out_mon.kind, vch: out_mon.virtual_channel, sample: out_mon.sample,
            irq: out_mon.touch_irq, wake: out_mon.wake_pulse, last: out_mon.last};
    checked++;
    if (expected_q.size() == 0) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t: result transaction with nothing expected: %s", $time, show(got));
      fail_count++;
      return;
    end
    want = expected_q.pop_front();
    if (got.kind !== want.kind || got.vch !== want.vch || got.sample !== want.sample ||
        got.irq !== want.irq || got.wake !== want.wake || got.last !== want.last) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t: mismatch, expected %s, got %s", $time, show(want), show(got));
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs = '{channel_map: MAP_RESET, plate_x_first: X_FIRST_RESET,
               plate_x_last: X_LAST_RESET, plate_y_first: Y_FIRST_RESET,
               plate_y_last: Y_LAST_RESET, vddio_level: VDDIO_RESET,
               battery_level: BATTERY_RESET, touch_irq_enable: 1'b0};
      pos_x = '0;
      pos_y = '0;
      lift_x = '0;
      lift_y = '0;
      hold_x = '0;
      hold_y = '0;
      pen_on = 1'b0;
      hold_on = 1'b0;
      hold_live = 1'b0;
      touch_seen = 1'b0;
      pen_mode = PH_UP;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (cfg_write) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MAP:     regs.channel_map = cfg_data;
          CFG_X_FIRST: regs.plate_x_first = cfg_data[CNT_W-1:0];
          CFG_X_LAST:  regs.plate_x_last = cfg_data[CNT_W-1:0];
          CFG_Y_FIRST: regs.plate_y_first = cfg_data[CNT_W-1:0];
          CFG_Y_LAST:  regs.plate_y_last = cfg_data[CNT_W-1:0];
          CFG_VDDIO:   regs.vddio_level = cfg_data[CNT_W-1:0];
          CFG_BATTERY: regs.battery_level = cfg_data[CNT_W-1:0];
          CFG_IRQ_EN:  regs.touch_irq_enable = cfg_data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_item(op_t'(in_mon.op), in_mon.pointer_x, in_mon.pointer_y,
                     in_mon.pen_pressed, in_mon.channel_mask, in_mon.fresh_kick);
    end
    pending = expected_q.size();
  end

endmodule

### verif/tb.sv
module tb;
  import rtas_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int NUM_PHASES = 5;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count, pending, checked;
  int                    items_sent = 0;
  int                    settings_loaded = 0;
  int                    recv_stall = 0;
  bit                    send_calm = 1'b0;
  bit                    recv_calm = 1'b0;
  logic                  finger = 1'b0;

  rtas_in_if  in_ch ();
  rtas_out_if out_ch ();

  resistive_touch_adc_sampler DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  rtas_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  always @(negedge clk) begin
    if (recv_stall > 0) begin
      out_ch.ready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!recv_calm && $urandom_range(0, 3) == 0) recv_stall <= idle_len();
    end
  end

  // Returns at the falling edge after acceptance with valid still high, so a
  // following transaction with no gap keeps valid asserted without a glitch.
  task automatic send_item(input op_t op, input logic [15:0] x, input logic [15:0] y,
                           input logic pen, input logic [7:0] mask, input logic kick);
    int gap;
    gap = send_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.pointer_x <= x;
    in_ch.pointer_y <= y;
    in_ch.pen_pressed <= pen;
    in_ch.channel_mask <= mask;
    in_ch.fresh_kick <= kick;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    wait_drained();
    write_reg(CFG_MAP, s.channel_map);
    write_reg(CFG_X_FIRST, CFG_DATA_W'(s.plate_x_first));
    write_reg(CFG_X_LAST, CFG_DATA_W'(s.plate_x_last));
    write_reg(CFG_Y_FIRST, CFG_DATA_W'(s.plate_y_first));
    write_reg(CFG_Y_LAST, CFG_DATA_W'(s.plate_y_last));
    write_reg(CFG_VDDIO, CFG_DATA_W'(s.vddio_level));
    write_reg(CFG_BATTERY, CFG_DATA_W'(s.battery_level));
    write_reg(CFG_IRQ_EN, CFG_DATA_W'(s.touch_irq_enable));
    cfg_write <= 1'b0;
    @(negedge clk);
    settings_loaded++;
  endtask

  function automatic cfg_t phase_settings(int p);
    cfg_t s;
    int   i;
    case (p)
      0: s = '{channel_map: MAP_RESET, plate_x_first: X_FIRST_RESET,
               plate_x_last: X_LAST_RESET, plate_y_first: Y_FIRST_RESET,
               plate_y_last: Y_LAST_RESET, vddio_level: VDDIO_RESET,
               battery_level: BATTERY_RESET, touch_irq_enable: 1'b1};
      1: s = '{channel_map: 32'hF7362534, plate_x_first: CNT_MAX, plate_x_last: '0,
               plate_y_first: '0, plate_y_last: CNT_MAX, vddio_level: '0,
               battery_level: CNT_MAX, touch_irq_enable: 1'b1};
      2: s = '0;
      3: s = '1;
      default: begin
        for (i = 0; i < 8; i++)
          s.channel_map[4*i +: 4] = ($urandom_range(0, 3) == 0) ?
                                    4'($urandom_range(0, 15)) : 4'($urandom_range(2, 7));
        s.plate_x_first = CNT_W'($urandom_range(0, 4095));
        s.plate_x_last = CNT_W'($urandom_range(0, 4095));
        s.plate_y_first = CNT_W'($urandom_range(0, 4095));
        s.plate_y_last = CNT_W'($urandom_range(0, 4095));
        s.vddio_level = CNT_W'($urandom_range(0, 4095));
        s.battery_level = CNT_W'($urandom_range(0, 4095));
        s.touch_irq_enable = 1'($urandom_range(0, 1));
      end
    endcase
    return s;
  endfunction

  function automatic logic [15:0] pick_pos();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 16'($urandom_range(0, 32767));
    if (r < 17) return 16'($urandom_range(32768, 65535));
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'h7fff;
      2: return 16'h8000;
      default: return 16'hffff;
    endcase
  endfunction

  // The finger flips now and then, so presses, holds and lifts come in
  // realistic runs with bursts in between.
  task automatic send_random_item();
    int         r;
    op_t        op;
    logic [7:0] mask;
    r = $urandom_range(0, 99);
    if (r < 45) op = OP_UPDATE;
    else if (r < 85) op = OP_BURST;
    else if (r < 95) op = OP_ACK;
    else op = OP_NONE;
    if ($urandom_range(0, 3) == 0) finger = !finger;
    case ($urandom_range(0, 9))
      0: mask = 8'h00;
      1: mask = 8'hff;
      2: mask = 8'h01 << $urandom_range(0, 7);
      default: mask = 8'($urandom_range(0, 255));
    endcase
    send_item(op, pick_pos(), pick_pos(), finger, mask, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int p, i;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_MAP;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_UPDATE;
    in_ch.pointer_x = '0;
    in_ch.pointer_y = '0;
    in_ch.pen_pressed = 1'b0;
    in_ch.channel_mask = '0;
    in_ch.fresh_kick = 1'b0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_settings(phase_settings(0));
    send_item(OP_ACK, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    send_item(OP_NONE, 16'hffff, 16'hffff, 1'b1, 8'hff, 1'b1);
    send_item(OP_BURST, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1);
    send_item(OP_BURST, 16'h0000, 16'h0000, 1'b0, 8'hff, 1'b0);
    send_item(OP_UPDATE, 16'hffff, 16'hffff, 1'b1, 8'h00, 1'b0);
    send_item(OP_BURST, 16'h0000, 16'h0000, 1'b0, 8'hff, 1'b1);
    send_item(OP_UPDATE, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0);
    send_item(OP_BURST, 16'h0000, 16'h0000, 1'b0, 8'h04, 1'b0);
    send_item(OP_BURST, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1);
    send_item(OP_UPDATE, 16'h8000, 16'h7fff, 1'b1, 8'h00, 1'b0);
    send_item(OP_BURST, 16'h0000, 16'h0000, 1'b0, 8'h08, 1'b0);
    send_item(OP_ACK, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    send_item(OP_UPDATE, 16'd100, 16'd200, 1'b0, 8'h00, 1'b0);
    send_item(OP_UPDATE, 16'd300, 16'd400, 1'b0, 8'h00, 1'b0);
    send_item(OP_BURST, 16'h0000, 16'h0000, 1'b0, 8'h0c, 1'b0);
    send_item(OP_BURST, 16'h0000, 16'h0000, 1'b0, 8'h3c, 1'b1);
    send_item(OP_UPDATE, 16'd12345, 16'd23456, 1'b1, 8'h00, 1'b0);
    send_item(OP_UPDATE, 16'd12345, 16'd23456, 1'b0, 8'h00, 1'b0);
    send_item(OP_UPDATE, 16'd5, 16'd6, 1'b1, 8'h00, 1'b0);
    send_item(OP_BURST, 16'h0000, 16'h0000, 1'b1, 8'h20, 1'b1);
    send_item(OP_ACK, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0);
    send_item(OP_BURST, 16'h0000, 16'h0000, 1'b1, 8'hc3, 1'b0);

    for (p = 1; p <= NUM_PHASES; p++) begin
      load_settings(phase_settings(p));
      send_calm = (p == 3);
      recv_calm = (p == 3) || (p == 5);
      for (i = 0; i < ((p < 4) ? 20 : 24); i++) begin
        send_random_item();
        if (i == 8) wait_drained();
      end
    end

    send_calm = 1'b0;
    recv_calm = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk);
    $display("Sent %0d input transactions under %0d register settings, with updates,",
             items_sent, settings_loaded);
    $display("bursts, acknowledges and undefined ops; %0d result transactions checked.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
